### hw/rtl/nprs_pkg.sv
// Shared types and constants for the NAND page read sequencer.
// Used by nprs_front, nprs_queue, nprs_back and the top level; no dependencies.
package nprs_pkg;

    localparam int INDEX_W   = 24;
    localparam int ROW_W     = 24;
    localparam int COL_W     = 16;
    localparam int STEP_W    = 4;

    localparam int QUEUE_DEPTH = 4;

    // Output operation codes.
    localparam logic [2:0] OP_SELECT   = 3'd0;
    localparam logic [2:0] OP_CMD      = 3'd1;
    localparam logic [2:0] OP_ADDR     = 3'd2;
    localparam logic [2:0] OP_WAIT     = 3'd3;
    localparam logic [2:0] OP_DATA     = 3'd4;
    localparam logic [2:0] OP_DESELECT = 3'd5;

    // Flash command bytes.
    localparam logic [7:0] CMD_READ         = 8'h00;
    localparam logic [7:0] CMD_READ_CONFIRM = 8'h30;

    // Positions within one expanded job.
    localparam logic [STEP_W-1:0] STEP_LEAD        = 4'd0;
    localparam logic [STEP_W-1:0] STEP_CMD_READ    = 4'd1;
    localparam logic [STEP_W-1:0] STEP_COL_LO      = 4'd2;
    localparam logic [STEP_W-1:0] STEP_COL_HI      = 4'd3;
    localparam logic [STEP_W-1:0] STEP_ROW_LO      = 4'd4;
    localparam logic [STEP_W-1:0] STEP_ROW_MID     = 4'd5;
    localparam logic [STEP_W-1:0] STEP_ROW_HI      = 4'd6;
    localparam logic [STEP_W-1:0] STEP_CMD_CONFIRM = 4'd7;
    localparam logic [STEP_W-1:0] STEP_WAIT        = 4'd8;
    localparam logic [STEP_W-1:0] STEP_DESELECT    = 4'd9;

    // One classified input item, expanded by the back end into its ops.
    typedef struct packed {
        logic               lead_data;   // lead op is a data delivery, else select
        logic               has_seq;     // read command sequence follows the lead op
        logic               has_desel;   // a deselect ends the job
        logic [7:0]         value;
        logic [INDEX_W-1:0] index;
        logic [COL_W-1:0]   column;
        logic [ROW_W-1:0]   page;
    } t_job;

endpackage

### hw/rtl/nand_page_read_sequencer_core.sv
// NAND page read sequencer. Jobs wait in the job queue; ops leave via a registered output stage.
// Input: one item per cycle while the four-entry job queue has room.
// Output: one op per cycle from the back end unless stalled; a request expands to 9 or 10 ops,
// a data byte to 1, 2 or 9 ops, so the back end's op counter sets sustained throughput.
// Reset (synchronous, active low) empties the queue and returns the sequencer to idle.
module nand_page_read_sequencer_core #(
    parameter int PAGE_BYTES  = 2048,
    parameter int LENGTH_BITS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_kind,
    input  logic [31:0]                  i_start_address,
    input  logic [23:0]                  i_length,
    input  logic [7:0]                   i_flash_byte,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [2:0]                   o_op,
    output logic [7:0]                   o_value,
    output logic [nprs_pkg::INDEX_W-1:0] o_buffer_index,
    output logic                         o_last
);

    logic           push, pop, full, empty;
    nprs_pkg::t_job push_job, head_job;

    assign o_stall = full;

    nprs_front #(
        .PAGE_BYTES  (PAGE_BYTES),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_kind          (i_kind),
        .i_start_address (i_start_address),
        .i_length        (i_length),
        .i_flash_byte    (i_flash_byte),
        .i_full          (full),
        .o_push          (push),
        .o_job           (push_job)
    );

    nprs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_full  (full),
        .o_empty (empty)
    );

    nprs_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job          (head_job),
        .i_empty        (empty),
        .o_pop          (pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_op           (o_op),
        .o_value        (o_value),
        .o_buffer_index (o_buffer_index),
        .o_last         (o_last)
    );

endmodule

### hw/rtl/nprs_front.sv
// Front end: accepts requests and flash data bytes, keeps the read state
// and turns each effective item into one job. Depends on nprs_pkg.
module nprs_front #(
    parameter int PAGE_BYTES  = 2048,
    parameter int LENGTH_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_kind,
    input  logic [31:0]          i_start_address,
    input  logic [23:0]          i_length,
    input  logic [7:0]           i_flash_byte,
    input  logic                 i_full,
    output logic                 o_push,
    output nprs_pkg::t_job       o_job
);

    // PAGE_BYTES must be a power of two (unchecked), so page and column split the address.
    localparam int CB = $clog2(PAGE_BYTES);
    localparam int LW = (LENGTH_BITS < nprs_pkg::INDEX_W) ? LENGTH_BITS : nprs_pkg::INDEX_W;

    logic                         r_busy, n_busy;
    logic [nprs_pkg::ROW_W-1:0]   r_page, n_page;
    logic [CB-1:0]                r_column, n_column;
    logic [LW-1:0]                r_done, n_done;
    logic [LW-1:0]                r_wanted, n_wanted;

    logic          accept;
    logic [LW-1:0] done_inc;

    assign accept   = i_valid && !i_full;
    assign done_inc = r_done + 1'b1;

    always_comb begin
        n_busy   = r_busy;
        n_page   = r_page;
        n_column = r_column;
        n_done   = r_done;
        n_wanted = r_wanted;
        o_push   = 1'b0;
        o_job    = '0;
        if (accept) begin
            if (!i_kind) begin
                if (!r_busy) begin
                    n_page   = nprs_pkg::ROW_W'(i_start_address >> CB);
                    n_column = i_start_address[CB-1:0];
                    n_wanted = i_length[LW-1:0];
                    n_done   = '0;
                    n_busy   = |n_wanted;
                    o_push          = 1'b1;
                    o_job.lead_data = 1'b0;
                    o_job.has_seq   = 1'b1;
                    o_job.has_desel = ~|n_wanted;
                    o_job.column    = nprs_pkg::COL_W'(n_column);
                    o_job.page      = n_page;
                end
            end else begin
                if (r_busy) begin
                    n_done   = done_inc;
                    n_column = r_column + 1'b1;
                    o_push          = 1'b1;
                    o_job.lead_data = 1'b1;
                    o_job.value     = i_flash_byte;
                    o_job.index     = nprs_pkg::INDEX_W'(r_done);
                    if (done_inc == r_wanted) begin
                        n_busy          = 1'b0;
                        o_job.has_desel = 1'b1;
                    end else if (&r_column) begin
                        // Page boundary: the column has already wrapped to zero.
                        n_page        = r_page + 1'b1;
                        o_job.has_seq = 1'b1;
                    end
                    o_job.column = nprs_pkg::COL_W'(n_column);
                    o_job.page   = n_page;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_page   <= '0;
            r_column <= '0;
            r_done   <= '0;
            r_wanted <= '0;
        end else begin
            r_busy   <= n_busy;
            r_page   <= n_page;
            r_column <= n_column;
            r_done   <= n_done;
            r_wanted <= n_wanted;
        end
    end

    property p_busy_has_work;
        @(posedge i_clk) disable iff (!i_rst_n)
            r_busy |-> (r_done != r_wanted);
    endproperty
    a_busy_has_work: assert property (p_busy_has_work)
        else $error("busy with all requested bytes already delivered");

endmodule

### hw/rtl/nprs_queue.sv
// Short job queue between the front and back ends.
// Register based, one write and one read per cycle. Depends on nprs_pkg.
module nprs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  nprs_pkg::t_job i_job,
    input  logic           i_pop,
    output nprs_pkg::t_job o_job,
    output logic           o_full,
    output logic           o_empty
);

    localparam int PW = $clog2(nprs_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(nprs_pkg::QUEUE_DEPTH + 1);

    nprs_pkg::t_job r_mem [nprs_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  r_wr, r_rd;
    logic [CW-1:0]  r_count;

    logic do_push, do_pop;

    assign o_full  = (r_count == CW'(nprs_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    property p_count_bound;
        @(posedge i_clk) disable iff (!i_rst_n)
            r_count <= CW'(nprs_pkg::QUEUE_DEPTH);
    endproperty
    a_count_bound: assert property (p_count_bound)
        else $error("queue count exceeds its depth");

    property p_pointer_gap;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_count != CW'(nprs_pkg::QUEUE_DEPTH)) |-> (PW'(r_wr - r_rd) == PW'(r_count));
    endproperty
    a_pointer_gap: assert property (p_pointer_gap)
        else $error("queue pointers disagree with the count");

endmodule

### hw/rtl/nprs_back.sv
// Back end: expands each queued job into its flash ops, one op per cycle while the output
// is not stalled, into a registered output stage. Depends on nprs_pkg.
module nprs_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  nprs_pkg::t_job               i_job,
    input  logic                         i_empty,
    output logic                         o_pop,
    input  logic                         i_stall,
    output logic                         o_valid,
    output logic [2:0]                   o_op,
    output logic [7:0]                   o_value,
    output logic [nprs_pkg::INDEX_W-1:0] o_buffer_index,
    output logic                         o_last
);

    logic                          r_valid;
    logic [nprs_pkg::STEP_W-1:0]   r_step;
    logic [2:0]                    r_op;
    logic [7:0]                    r_value;
    logic [nprs_pkg::INDEX_W-1:0]  r_index;
    logic                          r_last;

    logic                          advance, load;
    logic [nprs_pkg::STEP_W-1:0]   end_step;
    logic [2:0]                    n_op;
    logic [7:0]                    n_value;
    logic [nprs_pkg::INDEX_W-1:0]  n_index;
    logic                          n_last;

    assign advance = !r_valid || !i_stall;
    assign load    = advance && !i_empty;

    always_comb begin
        if (i_job.has_seq) begin
            end_step = i_job.has_desel ? nprs_pkg::STEP_DESELECT : nprs_pkg::STEP_WAIT;
        end else begin
            end_step = i_job.has_desel ? nprs_pkg::STEP_CMD_READ : nprs_pkg::STEP_LEAD;
        end
    end

    always_comb begin
        n_op    = nprs_pkg::OP_DESELECT;
        n_value = '0;
        n_index = '0;
        n_last  = (r_step == end_step);
        if (r_step == nprs_pkg::STEP_LEAD) begin
            if (i_job.lead_data) begin
                n_op    = nprs_pkg::OP_DATA;
                n_value = i_job.value;
                n_index = i_job.index;
            end else begin
                n_op = nprs_pkg::OP_SELECT;
            end
        end else if (i_job.has_seq && r_step != nprs_pkg::STEP_DESELECT) begin
            case (r_step)
                nprs_pkg::STEP_CMD_READ: begin
                    n_op    = nprs_pkg::OP_CMD;
                    n_value = nprs_pkg::CMD_READ;
                end
                nprs_pkg::STEP_COL_LO: begin
                    n_op    = nprs_pkg::OP_ADDR;
                    n_value = i_job.column[7:0];
                end
                nprs_pkg::STEP_COL_HI: begin
                    n_op    = nprs_pkg::OP_ADDR;
                    n_value = i_job.column[15:8];
                end
                nprs_pkg::STEP_ROW_LO: begin
                    n_op    = nprs_pkg::OP_ADDR;
                    n_value = i_job.page[7:0];
                end
                nprs_pkg::STEP_ROW_MID: begin
                    n_op    = nprs_pkg::OP_ADDR;
                    n_value = i_job.page[15:8];
                end
                nprs_pkg::STEP_ROW_HI: begin
                    n_op    = nprs_pkg::OP_ADDR;
                    n_value = i_job.page[23:16];
                end
                nprs_pkg::STEP_CMD_CONFIRM: begin
                    n_op    = nprs_pkg::OP_CMD;
                    n_value = nprs_pkg::CMD_READ_CONFIRM;
                end
                nprs_pkg::STEP_WAIT: begin
                    n_op = nprs_pkg::OP_WAIT;
                end
                default: begin
                    n_op = nprs_pkg::OP_DESELECT;
                end
            endcase
        end
    end

    // The job leaves the queue when its final op is loaded into the output stage.
    assign o_pop = load && n_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= nprs_pkg::STEP_LEAD;
        end else begin
            if (advance) begin
                r_valid <= !i_empty;
            end
            if (load) begin
                r_step <= n_last ? nprs_pkg::STEP_LEAD : r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_op    <= n_op;
            r_value <= n_value;
            r_index <= n_index;
            r_last  <= n_last;
        end
    end

    assign o_valid        = r_valid;
    assign o_op           = r_op;
    assign o_value        = r_value;
    assign o_buffer_index = r_index;
    assign o_last         = r_last;

    property p_desel_last;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_valid && r_op == nprs_pkg::OP_DESELECT) |-> r_last;
    endproperty
    a_desel_last: assert property (p_desel_last)
        else $error("deselect transfer not marked last");

    property p_seq_not_last;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_valid && (r_op == nprs_pkg::OP_SELECT || r_op == nprs_pkg::OP_CMD ||
                         r_op == nprs_pkg::OP_ADDR)) |-> !r_last;
    endproperty
    a_seq_not_last: assert property (p_seq_not_last)
        else $error("command sequence transfer marked last");

    property p_step_range;
        @(posedge i_clk) disable iff (!i_rst_n)
            r_step <= nprs_pkg::STEP_DESELECT;
    endproperty
    a_step_range: assert property (p_step_range)
        else $error("job step counter out of range");

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for nand_page_read_sequencer_core: directed table, then random reads.
// Depends on nprs_pkg and the core RTL; expected ops come from a predictor kept in this file.
module tb_top;

    localparam int PAGE_BYTES   = 2048;
    localparam int COL_BITS     = $clog2(PAGE_BYTES) + 1;
    localparam int RANDOM_ITEMS = 420;
    localparam int HOLD_CYCLES  = 500;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 750000;
    localparam int NUM_DIR      = 22;

    localparam logic KIND_REQ  = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    typedef struct packed {
        logic [2:0]                   op;
        logic [7:0]                   value;
        logic [nprs_pkg::INDEX_W-1:0] index;
        logic                         last;
    } t_nand_op;

    // Directed row: one item, plus what can be read off directly where typed is set.
    typedef struct packed {
        logic                         kind;
        logic [31:0]                  addr;
        logic [23:0]                  len;
        logic [7:0]                   fbyte;
        logic                         typed;
        logic [3:0]                   t_cnt;
        logic [2:0]                   t_op;
        logic [7:0]                   t_value;
        logic [nprs_pkg::INDEX_W-1:0] t_index;
    } t_dir_row;

    localparam t_dir_row DIR_ROWS [NUM_DIR] = '{
        '{KIND_DATA, 32'h00000000, 24'h000000, 8'hA5, 1'b1, 4'd0, nprs_pkg::OP_DATA, 8'h00, 24'd0},
        '{KIND_REQ, 32'h00000000, 24'h000000, 8'h00, 1'b1, 4'd10, nprs_pkg::OP_SELECT, 8'h00, 24'd0},
        '{KIND_REQ, 32'hFFFFFFFF, 24'h000000, 8'h00, 1'b1, 4'd10, nprs_pkg::OP_SELECT, 8'h00, 24'd0},
        '{KIND_REQ, 32'h000007FF, 24'h000003, 8'h00, 1'b0, 4'd0, nprs_pkg::OP_SELECT, 8'h00, 24'd0},
        '{KIND_DATA, 32'h00000000, 24'h000000, 8'hFF, 1'b1, 4'd9, nprs_pkg::OP_DATA, 8'hFF, 24'd0},
        '{KIND_REQ, 32'hFFFFFFFF, 24'hFFFFFF, 8'hFF, 1'b1, 4'd0, nprs_pkg::OP_SELECT, 8'h00, 24'd0},
        '{KIND_DATA, 32'h00000000, 24'h000000, 8'h00, 1'b1, 4'd1, nprs_pkg::OP_DATA, 8'h00, 24'd1},
        '{KIND_DATA, 32'h00000000, 24'h000000, 8'h5A, 1'b1, 4'd2, nprs_pkg::OP_DATA, 8'h5A, 24'd2},
        '{KIND_DATA, 32'h00000000, 24'h000000, 8'h3C, 1'b1, 4'd0, nprs_pkg::OP_DATA, 8'h00, 24'd0},
        '{KIND_REQ, 32'h12345678, 24'h000001, 8'h00, 1'b0, 4'd0, nprs_pkg::OP_SELECT, 8'h00, 24'd0},
        '{KIND_DATA, 32'h00000000, 24'h000000, 8'h81, 1'b1, 4'd2, nprs_pkg::OP_DATA, 8'h81, 24'd0},
        '{KIND_REQ, 32'hFFFFF800, 24'h000002, 8'h00, 1'b0, 4'd0, nprs_pkg::OP_SELECT, 8'h00, 24'd0},
        '{KIND_DATA, 32'h00000000, 24'h000000, 8'h7E, 1'b0, 4'd0, nprs_pkg::OP_DATA, 8'h00, 24'd0},
        '{KIND_DATA, 32'h00000000, 24'h000000, 8'hC3, 1'b0, 4'd0, nprs_pkg::OP_DATA, 8'h00, 24'd0},
        '{KIND_REQ, 32'h55555555, 24'h000000, 8'h00, 1'b1, 4'd10, nprs_pkg::OP_SELECT, 8'h00, 24'd0},
        '{KIND_REQ, 32'h000007FE, 24'h000004, 8'h00, 1'b0, 4'd0, nprs_pkg::OP_SELECT, 8'h00, 24'd0},
        '{KIND_DATA, 32'h00000000, 24'h000000, 8'h01, 1'b0, 4'd0, nprs_pkg::OP_DATA, 8'h00, 24'd0},
        '{KIND_DATA, 32'h00000000, 24'h000000, 8'h02, 1'b0, 4'd0, nprs_pkg::OP_DATA, 8'h00, 24'd0},
        '{KIND_DATA, 32'h00000000, 24'h000000, 8'h04, 1'b0, 4'd0, nprs_pkg::OP_DATA, 8'h00, 24'd0},
        '{KIND_DATA, 32'h00000000, 24'h000000, 8'h08, 1'b0, 4'd0, nprs_pkg::OP_DATA, 8'h00, 24'd0},
        '{KIND_REQ, 32'hAAAAA800, 24'h000001, 8'h00, 1'b0, 4'd0, nprs_pkg::OP_SELECT, 8'h00, 24'd0},
        '{KIND_DATA, 32'h00000000, 24'h000000, 8'h55, 1'b0, 4'd0, nprs_pkg::OP_DATA, 8'h00, 24'd0}
    };

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_stall;
    logic                         i_kind;
    logic [31:0]                  i_start_address;
    logic [23:0]                  i_length;
    logic [7:0]                   i_flash_byte;
    logic                         o_valid;
    logic                         i_stall;
    logic [2:0]                   o_op;
    logic [7:0]                   o_value;
    logic [nprs_pkg::INDEX_W-1:0] o_buffer_index;
    logic                         o_last;

    nand_page_read_sequencer_core #(
        .PAGE_BYTES (PAGE_BYTES),
        .LENGTH_BITS(24)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_kind         (i_kind),
        .i_start_address(i_start_address),
        .i_length       (i_length),
        .i_flash_byte   (i_flash_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_op           (o_op),
        .o_value        (o_value),
        .o_buffer_index (o_buffer_index),
        .o_last         (o_last)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predicted state of the sequencer.
    logic                rd_busy;
    logic [23:0]         rd_page;
    logic [COL_BITS-1:0] rd_col;
    logic [23:0]         rd_done;
    logic [23:0]         rd_wanted;

    t_nand_op op_expect_q[$];
    t_nand_op pending_op;
    t_nand_op first_op;
    t_nand_op head_op;
    logic     have_pending;
    int       item_ops;

    int mismatches;
    int results_seen;
    int cycle_count;
    int reads_started;
    int page_turns;
    int ignored_items;
    bit burst_mode;

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("[%0t] ERROR: %s", $time, what);
    endtask

    // The final op of an item carries last, so each op is held back until the next one shows up.
    function automatic void emit(input logic [2:0] op, input logic [7:0] value,
                                 input logic [nprs_pkg::INDEX_W-1:0] index);
        if (have_pending) op_expect_q.push_back(pending_op);
        pending_op   = '{op: op, value: value, index: index, last: 1'b0};
        have_pending = 1'b1;
        if (item_ops == 0) first_op = pending_op;
        item_ops++;
    endfunction

    function automatic void emit_read_cmds();
        logic [15:0] col16;
        col16 = 16'(rd_col);
        emit(nprs_pkg::OP_CMD, nprs_pkg::CMD_READ, '0);
        emit(nprs_pkg::OP_ADDR, col16[7:0], '0);
        emit(nprs_pkg::OP_ADDR, col16[15:8], '0);
        emit(nprs_pkg::OP_ADDR, rd_page[7:0], '0);
        emit(nprs_pkg::OP_ADDR, rd_page[15:8], '0);
        emit(nprs_pkg::OP_ADDR, rd_page[23:16], '0);
        emit(nprs_pkg::OP_CMD, nprs_pkg::CMD_READ_CONFIRM, '0);
        emit(nprs_pkg::OP_WAIT, 8'h00, '0);
    endfunction

    function automatic void predict_transfer(input logic kind, input logic [31:0] addr,
                                             input logic [23:0] len, input logic [7:0] fbyte);
        item_ops     = 0;
        have_pending = 1'b0;
        first_op     = '0;
        if (kind == KIND_REQ) begin
            if (rd_busy) begin
                ignored_items++;
            end else begin
                rd_page   = 24'(addr / PAGE_BYTES);
                rd_col    = COL_BITS'(addr % PAGE_BYTES);
                rd_done   = '0;
                rd_wanted = len;
                reads_started++;
                emit(nprs_pkg::OP_SELECT, 8'h00, '0);
                emit_read_cmds();
                if (rd_wanted == 0) emit(nprs_pkg::OP_DESELECT, 8'h00, '0);
                else rd_busy = 1'b1;
            end
        end else begin
            if (!rd_busy) begin
                ignored_items++;
            end else begin
                emit(nprs_pkg::OP_DATA, fbyte, rd_done);
                rd_done = rd_done + 1'b1;
                rd_col  = rd_col + 1'b1;
                if (rd_done == rd_wanted) begin
                    emit(nprs_pkg::OP_DESELECT, 8'h00, '0);
                    rd_busy = 1'b0;
                end else if (rd_col >= PAGE_BYTES) begin
                    rd_page = rd_page + 1'b1;
                    rd_col  = '0;
                    page_turns++;
                    emit_read_cmds();
                end
            end
        end
        if (have_pending) begin
            pending_op.last = 1'b1;
            op_expect_q.push_back(pending_op);
        end
    endfunction

    function automatic int pick_gap();
        int r;
        if ($urandom_range(0, 49) == 0) burst_mode = !burst_mode;
        if (burst_mode) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offers one item and returns once the transfer has happened, with its predicted op count.
    task automatic offer(input logic kind, input logic [31:0] addr, input logic [23:0] len,
                         input logic [7:0] fbyte, output int n);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_kind          <= kind;
        i_start_address <= addr;
        i_length        <= len;
        i_flash_byte    <= fbyte;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_transfer(kind, addr, len, fbyte);
        n = item_ops;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (op_expect_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected op %0d value %02h index %0d",
                                        o_op, o_value, o_buffer_index));
            end else begin
                head_op = op_expect_q.pop_front();
                if (o_op !== head_op.op)
                    flag_mismatch($sformatf("op %0d, want %0d", o_op, head_op.op));
                if (o_value !== head_op.value)
                    flag_mismatch($sformatf("value %02h, want %02h (op %0d)",
                                            o_value, head_op.value, head_op.op));
                if (o_buffer_index !== head_op.index)
                    flag_mismatch($sformatf("buffer index %0d, want %0d (op %0d)",
                                            o_buffer_index, head_op.index, head_op.op));
                if (o_last !== head_op.last)
                    flag_mismatch($sformatf("last %0b, want %0b (op %0d)",
                                            o_last, head_op.last, head_op.op));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d ops still expected",
                     cycle_count, op_expect_q.size());
            $display("nand_page_read_sequencer_core: mismatch");
            $finish;
        end
    end

    // Output side pacing: short and long stalls, calm stretches, and one long hold-off.
    initial begin : rx_pacing
        int  stall_left;
        int  hold_left;
        bit  held;
        bit  calm;
        stall_left = 0;
        hold_left  = 0;
        held       = 1'b0;
        calm       = 1'b0;
        i_stall    = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && results_seen >= 150) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if ($urandom_range(0, 199) == 0) calm = !calm;
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 99) < 20) begin
                stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                           : $urandom_range(0, 2);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin : stimulus
        int          n;
        int          useful;
        int          len;
        bit          drained;
        logic [31:0] addr;

        rd_busy         = 1'b0;
        rd_page         = '0;
        rd_col          = '0;
        rd_done         = '0;
        rd_wanted       = '0;
        have_pending    = 1'b0;
        item_ops        = 0;
        mismatches      = 0;
        results_seen    = 0;
        cycle_count     = 0;
        reads_started   = 0;
        page_turns      = 0;
        ignored_items   = 0;
        burst_mode      = 1'b0;
        useful          = 0;
        drained         = 1'b0;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_kind          = KIND_REQ;
        i_start_address = '0;
        i_length        = '0;
        i_flash_byte    = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIR_ROWS[k]) begin
            offer(DIR_ROWS[k].kind, DIR_ROWS[k].addr, DIR_ROWS[k].len, DIR_ROWS[k].fbyte, n);
            if (DIR_ROWS[k].typed) begin
                if (n != DIR_ROWS[k].t_cnt ||
                    (n > 0 && (first_op.op != DIR_ROWS[k].t_op ||
                               first_op.value != DIR_ROWS[k].t_value ||
                               first_op.index != DIR_ROWS[k].t_index)))
                    flag_mismatch($sformatf("directed row %0d: %0d ops, first op %0d value %02h",
                                            k, n, first_op.op, first_op.value));
            end
        end

        while (useful < RANDOM_ITEMS) begin
            if (!drained && useful >= RANDOM_ITEMS / 2) begin
                // Let the block run completely dry once before carrying on.
                drained = 1'b1;
                i_valid <= 1'b0;
                while (op_expect_q.size() != 0) @(posedge i_clk);
            end
            case ($urandom_range(0, 99)) inside
                [0:7]: begin
                    offer(KIND_REQ, $urandom(), 24'd0, 8'($urandom()), n);
                    if (n > 0) useful++;
                end
                [8:12]: begin
                    offer(KIND_DATA, $urandom(), 24'($urandom()), 8'($urandom()), n);
                    if (n > 0) useful++;
                end
                default: begin
                    addr = $urandom();
                    if ($urandom_range(0, 9) < 4)
                        addr = addr - (addr % PAGE_BYTES) + PAGE_BYTES - 1 - $urandom_range(0, 5);
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40)
                                                      : $urandom_range(1, 10);
                    offer(KIND_REQ, addr, 24'(len), 8'($urandom()), n);
                    if (n > 0) useful++;
                    for (int b = 0; b < len; b++) begin
                        // A request in the middle of a read must be dropped by the block.
                        if (rd_busy && $urandom_range(0, 24) == 0)
                            offer(KIND_REQ, $urandom(), 24'($urandom()), 8'($urandom()), n);
                        // Occasionally abandon the read part way through.
                        if ($urandom_range(0, 32) == 0) break;
                        offer(KIND_DATA, $urandom(), 24'($urandom()), 8'($urandom()), n);
                        if (n > 0) useful++;
                    end
                end
            endcase
        end

        // Finish any abandoned read, then start a maximum-length read at the top address.
        while (rd_busy) offer(KIND_DATA, '0, '0, 8'($urandom()), n);
        offer(KIND_REQ, 32'hFFFF_FFFF, 24'hFF_FFFF, 8'h00, n);
        repeat (6) offer(KIND_DATA, '0, '0, 8'($urandom()), n);
        i_valid <= 1'b0;

        while (op_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d reads, %0d page turns, %0d ignored items; %0d ops checked",
                 reads_started, page_turns, ignored_items, results_seen);
        if (mismatches == 0) begin
            $display("nand_page_read_sequencer_core: match");
        end else begin
            $display("%0d errors", mismatches);
            $display("nand_page_read_sequencer_core: mismatch");
        end
        $finish;
    end

endmodule

### nand_page_read_sequencer_core.f
hw/rtl/nprs_pkg.sv
hw/rtl/nprs_front.sv
hw/rtl/nprs_queue.sv
hw/rtl/nprs_back.sv
hw/rtl/nand_page_read_sequencer_core.sv
dv/tb_top.sv
